// ===== hdl/crc32u_pkg.sv =====
// Shared types, codes and bit-reversal helpers for the byte-fed CRC-32 unit.
package crc32u_pkg;

	localparam int unsigned CRC_W      = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] INIT_RESET = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] CRC_RESET  = 32'hFFFF_FFFF;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_POLYNOMIAL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VALUE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_IN    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REVERSE_OUT   = 2'd3;

	// item kinds
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

	typedef struct packed {
		logic [CRC_W-1:0] polynomial;
		logic [CRC_W-1:0] initial_value;
		logic             reverse_input_bytes;
		logic             reverse_output;
	} crc32u_cfg_t;

	function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = b[BYTE_W-1-i];
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] flip_word(input logic [CRC_W-1:0] w);
		logic [CRC_W-1:0] r;
		for (int i = 0; i < CRC_W; i++) begin
			r[i] = w[CRC_W-1-i];
		end
		return r;
	endfunction

endpackage

// ===== hdl/crc32u_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
interface crc32u_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface crc32u_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_value;

	modport source (output valid, output crc_value, input ready);
	modport sink (input valid, input crc_value, output ready);
endinterface

// ===== hdl/crc32_unit_byte_fed_core.sv =====
// Top level of the byte-fed programmable CRC-32 unit.
// The result of an accepted item shows on out_ch from the next cycle on.
// Throughput: one item per cycle while out_ch is not stalled; the byte update is an unrolled 8-step XOR
// network between the CRC register and the result register.
// Reset (arst_n low): CRC register to all ones, configuration to its defaults,
// result register empty.
module crc32_unit_byte_fed_core
	import crc32u_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	crc32u_in_if.sink             in_ch,
	crc32u_out_if.source          out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	crc32u_cfg_t      cfg_q;
	logic [CRC_W-1:0] crc_q;
	logic             out_valid_q;
	logic [CRC_W-1:0] result_q;

	logic             in_acc;
	logic [CRC_W-1:0] step_crc;
	logic [CRC_W-1:0] crc_next;

	// take a new item whenever the result register is empty or being drained
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign in_acc      = in_ch.valid && in_ch.ready;

	crc32u_step u_step (
		.crc       (crc_q),
		.data_byte (in_ch.data_byte),
		.cfg       (cfg_q),
		.crc_next  (step_crc)
	);

	assign crc_next = (in_ch.kind == KIND_RESTART) ? cfg_q.initial_value : step_crc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.polynomial          <= POLY_RESET;
			cfg_q.initial_value       <= INIT_RESET;
			cfg_q.reverse_input_bytes <= 1'b0;
			cfg_q.reverse_output      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLYNOMIAL:    cfg_q.polynomial          <= cfg_data[CRC_W-1:0];
				CFG_INITIAL_VALUE: cfg_q.initial_value       <= cfg_data[CRC_W-1:0];
				CFG_REVERSE_IN:    cfg_q.reverse_input_bytes <= cfg_data[0];
				CFG_REVERSE_OUT:   cfg_q.reverse_output      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				crc_q       <= crc_next;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			result_q <= cfg_q.reverse_output ? flip_word(crc_next) : crc_next;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.crc_value = result_q;

`ifndef SYNTHESIS
	// restart loads the programmed initial value
	a_restart_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_ch.kind == KIND_RESTART) |=> crc_q == $past(cfg_q.initial_value))
		else $error("restart did not load initial value");

	// every accepted item leaves a result behind
	a_result_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid_q)
		else $error("accepted item produced no result");

	// a stalled result is neither dropped nor replaced
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ch.ready |=> out_valid_q && $stable(result_q))
		else $error("stalled result lost or overwritten");

	// the CRC register moves only on an accepted item
	a_crc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(crc_q))
		else $error("CRC register changed without an item");
`endif

endmodule

// ===== hdl/crc32u_step.sv =====
// Unrolled eight-bit MSB-first CRC update with a programmable polynomial.
module crc32u_step
	import crc32u_pkg::*;
(
	input  logic [CRC_W-1:0]  crc,
	input  logic [BYTE_W-1:0] data_byte,
	input  crc32u_cfg_t       cfg,
	output logic [CRC_W-1:0]  crc_next
);

	logic [BYTE_W-1:0] byte_in;
	logic [CRC_W-1:0]  r;

	assign byte_in = cfg.reverse_input_bytes ? flip_byte(data_byte) : data_byte;

	always_comb begin
		r = crc ^ {byte_in, {(CRC_W-BYTE_W){1'b0}}};
		for (int i = 0; i < BYTE_W; i++) begin
			r = r[CRC_W-1] ? ({r[CRC_W-2:0], 1'b0} ^ cfg.polynomial) : {r[CRC_W-2:0], 1'b0};
		end
		crc_next = r;
	end

endmodule
